// ===== rtl/lsf_pkg.sv =====
`default_nettype none

package lsf_pkg;

	localparam int MAX_LINE_WIDTH = 4096;
	localparam int MAX_FRAME_ROWS = 4096;
	localparam int MIN_DIM        = 3;

	localparam int PIX_W     = 14;
	localparam int COL_W     = 12;
	localparam int ROW_W     = 12;
	localparam int DIM_W     = 13;
	localparam int STR_W     = 16;
	localparam int DITH_W    = 8;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;

	// 4*c - (u+d+l+r) spans +-4*(2^PIX_W-1)
	localparam int WEIGHT_W = PIX_W + 3;
	localparam int PROD_W   = WEIGHT_W + STR_W + 1;
	localparam int Q_SHIFT  = 16;
	localparam int ADJ_W    = PROD_W - Q_SHIFT;
	localparam int RES_W    = ADJ_W + 1;

	localparam int ROUND_BIAS = 1 << (Q_SHIFT - 1);

	localparam logic [DIM_W-1:0] RST_LINE_WIDTH = DIM_W'(1920);
	localparam logic [DIM_W-1:0] RST_FRAME_ROWS = DIM_W'(1080);
	localparam logic [STR_W-1:0] RST_STRENGTH   = '0;
	localparam logic [PIX_W-1:0] RST_MAX_VALUE  = PIX_W'(255);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LINE_WIDTH    = 3'd0,
		REG_FRAME_ROWS    = 3'd1,
		REG_STRENGTH_Q16  = 3'd2,
		REG_MAX_VALUE     = 3'd3,
		REG_DITHER_ENABLE = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic             en;
		logic [COL_W-1:0] addr;
	} lb_rd_t;

	typedef struct packed {
		logic             en;
		logic [COL_W-1:0] addr;
		logic [PIX_W-1:0] pix;
	} lb_wr_t;

	typedef struct packed {
		logic signed [DITH_W-1:0] dith;
		logic [COL_W-1:0]         col;
		logic [ROW_W-1:0]         row;
		logic                     last;
	} meta_t;

	typedef struct packed {
		logic ld_s3;
		logic ld_s4;
		logic ld_out;
	} stage_en_t;

	typedef struct packed {
		logic [STR_W-1:0] strength;
		logic [PIX_W-1:0] max_value;
		logic             dither_en;
	} arith_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/laplacian_sharpen_filter_top.sv =====
`default_nettype none

// channel | handshake           | payload
// input   | in_valid / in_stall   | pixel_in, dither_value
// output  | out_valid / out_stall | sharpened, out_column, out_row, frame_last
// config  | cfg_write             | cfg_index, cfg_data
//
// One pixel per cycle unless out_stall backs up; results pass stage 1, the
// window, stages 3 and 4 and the output register. The line store keeps up:
// one read at accept, one write-back as the pixel leaves stage 1, on separate
// ports of each memory. Reset clears counters, window and valid flags; line
// stores are not cleared. in_stall rises only when the output holds a stalled
// result and every stage below it is full.

module laplacian_sharpen_filter_top import lsf_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [PIX_W-1:0]      pixel_in,
	input  wire logic signed [DITH_W-1:0] dither_value,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [PIX_W-1:0]           sharpened,
	output logic [COL_W-1:0]           out_column,
	output logic [ROW_W-1:0]           out_row,
	output logic                       frame_last,
	input  wire logic                  cfg_write,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_W-1:0]      cfg_data
);

	logic [DIM_W-1:0] line_width_q, frame_rows_q;
	arith_cfg_t       acfg_q;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [DIM_W-1:0] width_eff, rows_eff, col_nxt, row_nxt;

	logic             valid_s1, valid_s2, valid_s3, valid_s4, out_valid_q;
	logic [PIX_W-1:0] pix_s1;
	logic [COL_W-1:0] col_s1;
	logic             emit_s1;
	meta_t            meta_s1, meta_s2;

	logic rdy_out, rdy_s4, rdy_s3, rdy_s2, rdy_s1;
	logic accept, shift;
	logic emit;
	meta_t meta_in;

	lb_rd_t    lb_rd;
	lb_wr_t    lb_wr;
	stage_en_t sen;

	logic [PIX_W-1:0]           lb_up, lb_mid, centre;
	logic signed [WEIGHT_W-1:0] weight;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q     <= RST_LINE_WIDTH;
			frame_rows_q     <= RST_FRAME_ROWS;
			acfg_q.strength  <= RST_STRENGTH;
			acfg_q.max_value <= RST_MAX_VALUE;
			acfg_q.dither_en <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LINE_WIDTH:    line_width_q     <= cfg_data[DIM_W-1:0];
				REG_FRAME_ROWS:    frame_rows_q     <= cfg_data[DIM_W-1:0];
				REG_STRENGTH_Q16:  acfg_q.strength  <= cfg_data[STR_W-1:0];
				REG_MAX_VALUE:     acfg_q.max_value <= cfg_data[PIX_W-1:0];
				REG_DITHER_ENABLE: acfg_q.dither_en <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (line_width_q < DIM_W'(MIN_DIM))
			width_eff = DIM_W'(MIN_DIM);
		else if (line_width_q > DIM_W'(MAX_LINE_WIDTH))
			width_eff = DIM_W'(MAX_LINE_WIDTH);
		else
			width_eff = line_width_q;
		if (frame_rows_q < DIM_W'(MIN_DIM))
			rows_eff = DIM_W'(MIN_DIM);
		else if (frame_rows_q > DIM_W'(MAX_FRAME_ROWS))
			rows_eff = DIM_W'(MAX_FRAME_ROWS);
		else
			rows_eff = frame_rows_q;
	end

	// stage readiness, output side first
	assign rdy_out = !out_valid_q || !out_stall;
	assign rdy_s4  = !valid_s4 || rdy_out;
	assign rdy_s3  = !valid_s3 || rdy_s4;
	assign rdy_s2  = !valid_s2 || rdy_s3;
	assign rdy_s1  = !valid_s1 || rdy_s2;
	assign in_stall = !rdy_s1;
	assign accept   = in_valid && rdy_s1;
	// every transaction shifts the window, emitting or not
	assign shift    = valid_s1 && rdy_s2;

	assign col_nxt = DIM_W'(col_q) + DIM_W'(1);
	assign row_nxt = DIM_W'(row_q) + DIM_W'(1);
	assign emit    = (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2));

	assign meta_in.dith = dither_value;
	assign meta_in.col  = col_q - COL_W'(1);
	assign meta_in.row  = row_q - ROW_W'(1);
	assign meta_in.last = (row_nxt == rows_eff) && (col_nxt == width_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_nxt >= width_eff) begin
				col_q <= '0;
				row_q <= (row_nxt >= rows_eff) ? '0 : row_nxt[ROW_W-1:0];
			end else begin
				col_q <= col_nxt[COL_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy_s1)  valid_s1    <= in_valid;
			if (rdy_s2)  valid_s2    <= valid_s1 && emit_s1;
			if (rdy_s3)  valid_s3    <= valid_s2;
			if (rdy_s4)  valid_s4    <= valid_s3;
			if (rdy_out) out_valid_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1  <= pixel_in;
			col_s1  <= col_q;
			emit_s1 <= emit;
			meta_s1 <= meta_in;
		end
		if (shift)
			meta_s2 <= meta_s1;
	end

	assign lb_rd.en   = accept;
	assign lb_rd.addr = col_q;
	assign lb_wr.en   = shift;
	assign lb_wr.addr = col_s1;
	assign lb_wr.pix  = pix_s1;

	assign sen.ld_s3  = rdy_s3;
	assign sen.ld_s4  = rdy_s4;
	assign sen.ld_out = rdy_out;

	lsf_line_buf u_line_buf (
		.clk (clk),
		.rd  (lb_rd),
		.wr  (lb_wr),
		.up  (lb_up),
		.mid (lb_mid)
	);

	lsf_window u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.shift  (shift),
		.up     (lb_up),
		.mid    (lb_mid),
		.pix    (pix_s1),
		.centre (centre),
		.weight (weight)
	);

	lsf_sharpen u_sharpen (
		.clk        (clk),
		.en         (sen),
		.cfg        (acfg_q),
		.weight     (weight),
		.centre     (centre),
		.meta       (meta_s2),
		.sharpened  (sharpened),
		.out_column (out_column),
		.out_row    (out_row),
		.frame_last (frame_last)
	);

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/lsf_line_buf.sv =====
`default_nettype none

module lsf_line_buf import lsf_pkg::*; (
	input  wire logic             clk,
	input  wire lb_rd_t           rd,
	input  wire lb_wr_t           wr,
	output logic [PIX_W-1:0]      up,
	output logic [PIX_W-1:0]      mid
);

	logic [PIX_W-1:0] upper_mem  [MAX_LINE_WIDTH];
	logic [PIX_W-1:0] middle_mem [MAX_LINE_WIDTH];
	logic [PIX_W-1:0] up_q;
	logic [PIX_W-1:0] mid_q;

	// read at accept; the write-back happens when the same transaction leaves
	// stage 1, so mid_q is still the value read for that column
	always_ff @(posedge clk) begin
		if (rd.en) begin
			up_q  <= upper_mem[rd.addr];
			mid_q <= middle_mem[rd.addr];
		end
		if (wr.en) begin
			upper_mem[wr.addr]  <= mid_q;
			middle_mem[wr.addr] <= wr.pix;
		end
	end

	assign up  = up_q;
	assign mid = mid_q;

endmodule

`default_nettype wire

// ===== rtl/lsf_window.sv =====
`default_nettype none

module lsf_window import lsf_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                shift,
	input  wire logic [PIX_W-1:0]    up,
	input  wire logic [PIX_W-1:0]    mid,
	input  wire logic [PIX_W-1:0]    pix,
	output logic [PIX_W-1:0]         centre,
	output logic signed [WEIGHT_W-1:0] weight
);

	// corner taps never feed the stencil, so only seven are kept
	logic [PIX_W-1:0] l_mid_q;
	logic [PIX_W-1:0] c_top_q, c_mid_q, c_bot_q;
	logic [PIX_W-1:0] r_top_q, r_mid_q, r_bot_q;
	logic [WEIGHT_W-1:0] ring;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l_mid_q <= '0;
			c_top_q <= '0;
			c_mid_q <= '0;
			c_bot_q <= '0;
			r_top_q <= '0;
			r_mid_q <= '0;
			r_bot_q <= '0;
		end else if (shift) begin
			l_mid_q <= c_mid_q;
			c_top_q <= r_top_q;
			c_mid_q <= r_mid_q;
			c_bot_q <= r_bot_q;
			r_top_q <= up;
			r_mid_q <= mid;
			r_bot_q <= pix;
		end
	end

	assign ring = WEIGHT_W'(c_top_q) + WEIGHT_W'(c_bot_q) + WEIGHT_W'(l_mid_q)
		+ WEIGHT_W'(r_mid_q);
	assign weight = $signed({1'b0, c_mid_q, 2'b00}) - $signed(ring);
	assign centre = c_mid_q;

endmodule

`default_nettype wire

// ===== rtl/lsf_sharpen.sv =====
`default_nettype none

module lsf_sharpen import lsf_pkg::*; (
	input  wire logic                  clk,
	input  wire stage_en_t             en,
	input  wire arith_cfg_t            cfg,
	input  wire logic signed [WEIGHT_W-1:0] weight,
	input  wire logic [PIX_W-1:0]      centre,
	input  wire meta_t                 meta,
	output logic [PIX_W-1:0]           sharpened,
	output logic [COL_W-1:0]           out_column,
	output logic [ROW_W-1:0]           out_row,
	output logic                       frame_last
);

	logic signed [WEIGHT_W-1:0] weight_s3;
	logic [PIX_W-1:0]           centre_s3, centre_s4;
	meta_t                      meta_s3, meta_s4;
	logic signed [PROD_W-1:0]   prod_s4;

	logic signed [PROD_W-1:0] w_ext, s_ext, prod;
	logic signed [ADJ_W-1:0]  adj;
	logic signed [RES_W-1:0]  dith_ext, res, max_ext;
	logic [PIX_W-1:0]         clamped;

	assign w_ext = PROD_W'(weight_s3);
	assign s_ext = $signed(PROD_W'(cfg.strength));
	assign prod  = w_ext * s_ext + PROD_W'(ROUND_BIAS);

	// arithmetic shift: floor toward minus infinity
	assign adj      = $signed(prod_s4[PROD_W-1:Q_SHIFT]);
	assign dith_ext = cfg.dither_en ? RES_W'(meta_s4.dith) : '0;
	assign res      = RES_W'($signed({1'b0, centre_s4})) + RES_W'(adj) + dith_ext;
	assign max_ext  = $signed({{(RES_W-PIX_W){1'b0}}, cfg.max_value});

	always_comb begin
		if (res[RES_W-1])
			clamped = '0;
		else if (res > max_ext)
			clamped = cfg.max_value;
		else
			clamped = res[PIX_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en.ld_s3) begin
			weight_s3 <= weight;
			centre_s3 <= centre;
			meta_s3   <= meta;
		end
		if (en.ld_s4) begin
			prod_s4   <= prod;
			centre_s4 <= centre_s3;
			meta_s4   <= meta_s3;
		end
		if (en.ld_out) begin
			sharpened  <= clamped;
			out_column <= meta_s4.col;
			out_row    <= meta_s4.row;
			frame_last <= meta_s4.last;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/lsf_checker.sv =====
`default_nettype none

module lsf_checker import lsf_pkg::*; (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  in_valid,
	input wire logic                  in_stall,
	input wire logic [PIX_W-1:0]      pixel_in,
	input wire logic signed [DITH_W-1:0] dither_value,
	input wire logic                  out_valid,
	input wire logic                  out_stall,
	input wire logic [PIX_W-1:0]      sharpened,
	input wire logic [COL_W-1:0]      out_column,
	input wire logic [ROW_W-1:0]      out_row,
	input wire logic                  frame_last,
	input wire logic                  cfg_write
);

	// a stalled result holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sharpened)
			&& $stable(out_column) && $stable(out_row) && $stable(frame_last))
		else $error("stalled output transaction changed");

	// with an empty output register nothing can back up to the input
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

	// pixels of the first column and the first row are never emitted
	a_interior: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_column != '0 && out_row != '0)
		else $error("edge pixel emitted");

	// a stalled input transaction holds until taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(pixel_in) && $stable(dither_value))
		else $error("stalled input transaction changed");

	// registers only change with both channels idle
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_write |-> !in_valid && !out_valid)
		else $error("register write with transactions pending");

endmodule

bind laplacian_sharpen_filter_top lsf_checker u_lsf_checker (.*);

`default_nettype wire

// ===== bench/laplacian_sharpen_filter_top_test.sv =====
`timescale 1ns / 100ps

module laplacian_sharpen_filter_top_test;
	import lsf_pkg::*;

	localparam int GAP_MAX      = 11;
	localparam int SETTLE_TICKS = 12;
	localparam int QUIET_LIMIT  = 4000;
	localparam int RANDOM_ITEMS = 260;
	localparam int PRESSURE_AT  = 130;

	typedef struct packed {
		logic [PIX_W-1:0] pix;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             last;
	} pix_result_t;

	logic                     clk          = 1'b0;
	logic                     arst_n       = 1'b0;
	logic                     in_valid     = 1'b0;
	logic [PIX_W-1:0]         pixel_in     = '0;
	logic signed [DITH_W-1:0] dither_value = '0;
	logic                     out_stall    = 1'b0;
	logic                     cfg_write    = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index    = REG_LINE_WIDTH;
	logic [CFG_W-1:0]         cfg_data     = '0;
	logic                     in_stall;
	logic                     out_valid;
	logic [PIX_W-1:0]         sharpened;
	logic [COL_W-1:0]         out_column;
	logic [ROW_W-1:0]         out_row;
	logic                     frame_last;

	// prediction state
	logic [PIX_W-1:0] upper_line  [MAX_LINE_WIDTH] = '{default: '0};
	logic [PIX_W-1:0] middle_line [MAX_LINE_WIDTH] = '{default: '0};
	logic [PIX_W-1:0] win [9] = '{default: '0};
	int unsigned      col_pos      = 0;
	int unsigned      row_pos      = 0;
	logic [DIM_W-1:0] width_reg    = RST_LINE_WIDTH;
	logic [DIM_W-1:0] rows_reg     = RST_FRAME_ROWS;
	logic [STR_W-1:0] strength_reg = RST_STRENGTH;
	logic [PIX_W-1:0] clamp_reg    = RST_MAX_VALUE;
	logic             dither_reg   = 1'b0;
	pix_result_t      sharpened_q [$];

	bit          gaps_on        = 1'b1;
	int          mismatch_count = 0;
	int          quiet_cycles   = 0;
	int          random_items   = 0;
	pix_result_t got_res, want_res;

	laplacian_sharpen_filter_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.pixel_in     (pixel_in),
		.dither_value (dither_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sharpened    (sharpened),
		.out_column   (out_column),
		.out_row      (out_row),
		.frame_last   (frame_last),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned eff_dim(input logic [DIM_W-1:0] v, input int unsigned hi);
		int unsigned n;
		n = {{(32-DIM_W){1'b0}}, v};
		if (n < MIN_DIM)
			return MIN_DIM;
		if (n > hi)
			return hi;
		return n;
	endfunction

	task automatic sharpen_predict(input logic [PIX_W-1:0] pix,
			input logic signed [DITH_W-1:0] dith);
		int unsigned      width, rows;
		logic [PIX_W-1:0] up, mid;
		longint           c, weight, res;
		pix_result_t      r;
		int               i;
		width = eff_dim(width_reg, MAX_LINE_WIDTH);
		rows  = eff_dim(rows_reg, MAX_FRAME_ROWS);
		up  = upper_line[col_pos];
		mid = middle_line[col_pos];
		upper_line[col_pos]  = mid;
		middle_line[col_pos] = pix;
		for (i = 0; i < 6; i++)
			win[i] = win[i + 3];
		win[6] = up;
		win[7] = mid;
		win[8] = pix;
		if (row_pos >= 2 && col_pos >= 2) begin
			c = longint'(win[4]);
			weight = 4 * c - (longint'(win[3]) + longint'(win[5]) +
				longint'(win[1]) + longint'(win[7]));
			// arithmetic shift: rounds towards minus infinity
			res = c + ((weight * longint'(strength_reg) + 64'sd32768) >>> Q_SHIFT);
			if (dither_reg)
				res += longint'(dith);
			if (res < 0)
				res = 0;
			if (res > longint'(clamp_reg))
				res = longint'(clamp_reg);
			r.pix  = res[PIX_W-1:0];
			r.col  = COL_W'(col_pos - 1);
			r.row  = ROW_W'(row_pos - 1);
			r.last = (row_pos + 1 == rows) && (col_pos + 1 == width);
			sharpened_q.push_back(r);
		end
		// also covers a width or row count lowered below the current position
		if (col_pos + 1 >= width) begin
			col_pos = 0;
			row_pos = (row_pos + 1 >= rows) ? 0 : row_pos + 1;
		end else begin
			col_pos++;
		end
	endtask

	function automatic logic [PIX_W-1:0] rand_pixel();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return PIX_W'($urandom_range(0, clamp_reg));
			default: return PIX_W'($urandom());
		endcase
	endfunction

	task automatic push_pixel(input logic [PIX_W-1:0] pix, input logic [DITH_W-1:0] dith);
		if (gaps_on && $urandom_range(0, 9) == 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(0, GAP_MAX - 1)) @(negedge clk);
		end
		@(negedge clk);
		in_valid     <= 1'b1;
		pixel_in     <= pix;
		dither_value <= dith;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sharpen_predict(pix, dith);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_LINE_WIDTH:    width_reg    = data[DIM_W-1:0];
			REG_FRAME_ROWS:    rows_reg     = data[DIM_W-1:0];
			REG_STRENGTH_Q16:  strength_reg = data[STR_W-1:0];
			REG_MAX_VALUE:     clamp_reg    = data[PIX_W-1:0];
			REG_DITHER_ENABLE: dither_reg   = data[0];
			default: ;
		endcase
	endtask

	// lower valid, let every expected result out, then allow for pixels still in flight
	task automatic wait_results_done();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sharpened_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	task automatic set_config(input logic [CFG_W-1:0] width, input logic [CFG_W-1:0] rows,
			input logic [CFG_W-1:0] strength, input logic [CFG_W-1:0] maxv,
			input logic [CFG_W-1:0] dith_en);
		wait_results_done();
		write_reg(REG_LINE_WIDTH, width);
		write_reg(REG_FRAME_ROWS, rows);
		write_reg(REG_STRENGTH_Q16, strength);
		write_reg(REG_MAX_VALUE, maxv);
		write_reg(REG_DITHER_ENABLE, dith_en);
	endtask

	// random pixels up to the next frame boundary (a whole frame when at one)
	task automatic send_frame();
		do
			push_pixel(rand_pixel(), DITH_W'($urandom()));
		while (!(col_pos == 0 && row_pos == 0));
	endtask

	// 3x3 frame: one centre, a flat ring around it
	task automatic send_3x3(input logic [PIX_W-1:0] centre, input logic [PIX_W-1:0] ring,
			input logic [DITH_W-1:0] dith);
		int i;
		for (i = 0; i < 9; i++)
			push_pixel((i == 4) ? centre : ring, dith);
	endtask

	task automatic test_reset_values();
		// part of a row at the default width, then the row is cut short;
		// strength 0 and clamp 255 leave the clamped centre
		repeat (40)
			push_pixel(rand_pixel(), DITH_W'($urandom()));
		wait_results_done();
		write_reg(REG_LINE_WIDTH, CFG_W'(5));
		write_reg(REG_FRAME_ROWS, CFG_W'(4));
		send_frame();
	endtask

	task automatic test_extremes();
		set_config(16'd3, 16'd3, 16'hFFFF, 16'd16383, 16'd0);
		send_3x3('1, '0, '0);
		send_3x3('0, '1, '0);
		send_3x3(PIX_W'(100), PIX_W'(101), '0);
		set_config(16'd3, 16'd3, 16'd0, 16'd16383, 16'd1);
		send_3x3('1, '1, DITH_W'(127));
		send_3x3('0, '0, DITH_W'(-128));
		send_3x3(PIX_W'(5000), PIX_W'(5000), DITH_W'(-128));
	endtask

	task automatic test_clamp_values();
		set_config(16'd4, 16'd4, 16'd40000, 16'd0, 16'd1);
		send_frame();
		set_config(16'd5, 16'd4, 16'd12000, 16'd1000, 16'd1);
		send_frame();
		set_config(16'd4, 16'd3, 16'hFFFF, 16'd1023, 16'd0);
		send_frame();
	endtask

	task automatic test_width_cut();
		set_config(16'd8, 16'd6, 16'd20000, 16'd4095, 16'd1);
		repeat (3 * 8 + 5)
			push_pixel(rand_pixel(), DITH_W'($urandom()));
		wait_results_done();
		write_reg(REG_LINE_WIDTH, CFG_W'(4));
		repeat (6)
			push_pixel(rand_pixel(), DITH_W'($urandom()));
		wait_results_done();
		write_reg(REG_FRAME_ROWS, CFG_W'(3));
		send_frame();
	endtask

	task automatic test_dim_bounds();
		set_config(16'h0000, 16'h0001, 16'd30000, 16'd16383, 16'd0);
		send_frame();
		set_config(16'h0002, 16'h0000, 16'd30000, 16'd4095, 16'd1);
		send_frame();
		// bits above the register width are dropped
		set_config(16'h2005, 16'hE003, 16'd9000, 16'd1023, 16'd1);
		send_frame();
		// oversized width: part of a row, then the row is cut short
		set_config(16'hFFFF, 16'd3, 16'd50000, 16'd16383, 16'd1);
		repeat (20)
			push_pixel(rand_pixel(), DITH_W'($urandom()));
		wait_results_done();
		write_reg(REG_LINE_WIDTH, CFG_W'(6));
		send_frame();
		// oversized row count: rows past three, then the frame is cut short
		set_config(16'd3, 16'hFFFF, 16'd50000, 16'd255, 16'd0);
		repeat (15)
			push_pixel(rand_pixel(), DITH_W'($urandom()));
		wait_results_done();
		write_reg(REG_FRAME_ROWS, CFG_W'(3));
		send_frame();
	endtask

	task automatic test_random();
		logic [CFG_W-1:0] width, rows, strength, maxv;
		bit               pressure_done;
		pressure_done = 1'b0;
		while (random_items < RANDOM_ITEMS) begin
			width = ($urandom_range(0, 9) == 0) ? CFG_W'($urandom_range(0, 2))
				: CFG_W'($urandom_range(3, 14));
			rows  = ($urandom_range(0, 9) == 0) ? CFG_W'($urandom_range(0, 2))
				: CFG_W'($urandom_range(3, 7));
			case ($urandom_range(0, 3))
				0: strength = '0;
				1: strength = '1;
				default: strength = CFG_W'($urandom());
			endcase
			case ($urandom_range(0, 5))
				0: maxv = 16'd255;
				1: maxv = 16'd1023;
				2: maxv = 16'd4095;
				3: maxv = 16'd16383;
				default: maxv = CFG_W'($urandom_range(0, 16383));
			endcase
			set_config(width, rows, strength, maxv, CFG_W'($urandom_range(0, 1)));
			if (random_items < RANDOM_ITEMS - 120)
				gaps_on = ($urandom_range(0, 3) != 0);
			else
				gaps_on = 1'b0;
			repeat ($urandom_range(1, 2)) begin
				do begin
					push_pixel(rand_pixel(), DITH_W'($urandom()));
					random_items++;
					if (!pressure_done && random_items >= PRESSURE_AT && col_pos != 0) begin
						// hold the sender mid-frame until the output has caught up
						@(negedge clk);
						in_valid <= 1'b0;
						while (sharpened_q.size() != 0)
							@(posedge clk);
						pressure_done = 1'b1;
					end
				end while (!(col_pos == 0 && row_pos == 0));
			end
		end
	endtask

	task automatic note_mismatch(input string what, input pix_result_t want,
			input pix_result_t got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t %s: expected pix=%0d col=%0d row=%0d last=%0b, got pix=%0d col=%0d row=%0d last=%0b",
				$realtime, what, want.pix, want.col, want.row, want.last,
				got.pix, got.col, got.row, got.last);
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got_res = '{pix: sharpened, col: out_column, row: out_row, last: frame_last};
			if (sharpened_q.size() == 0) begin
				note_mismatch("unexpected result", '0, got_res);
			end else begin
				want_res = sharpened_q.pop_front();
				if (got_res !== want_res)
					note_mismatch("result mismatch", want_res, got_res);
			end
		end
	end

	// receiver stall bursts
	initial begin
		forever begin
			@(negedge clk);
			if (gaps_on && $urandom_range(0, 9) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, GAP_MAX)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_values();
		test_extremes();
		test_clamp_values();
		test_width_cut();
		test_dim_bounds();
		test_random();
		wait_results_done();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && sharpened_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
